[hdl/scope_frame_crc16_builder_top_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the frame builder.
// ---------------------------------------------------------------------------
`ifndef SCOPE_FRAME_CRC16_BUILDER_TOP_DEFINES_SVH
`define SCOPE_FRAME_CRC16_BUILDER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SFCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SFCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sfcb_pkg.sv]
// ---------------------------------------------------------------------------
// sfcb_pkg
// Types, constants and CRC-16/MODBUS helpers for the scope frame builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfcb_pkg;

  localparam int CHANNELS    = 8;
  localparam int DATA_BYTES  = 2 * CHANNELS;
  localparam int FRAME_BYTES = DATA_BYTES + 2;
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  // byte positions of the CRC trailer
  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(DATA_BYTES);
  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(DATA_BYTES + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic signed [15:0] sample_ch0;
    logic signed [15:0] sample_ch1;
    logic signed [15:0] sample_ch2;
    logic signed [15:0] sample_ch3;
    logic signed [15:0] sample_ch4;
    logic signed [15:0] sample_ch5;
    logic signed [15:0] sample_ch6;
    logic signed [15:0] sample_ch7;
  } in_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_res_t;

  // one byte through the reflected CRC, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // advance a CRC register over two zero bytes
  function automatic logic [15:0] crc_adv16(input logic [15:0] crc_in);
    return crc_byte(crc_byte(crc_in, 8'h00), 8'h00);
  endfunction

endpackage

[hdl/scope_frame_crc16_builder_top.sv]
// ---------------------------------------------------------------------------
// scope_frame_crc16_builder_top
// Serializes eight channel samples plus a CRC-16/MODBUS trailer as 18 bytes.
// ---------------------------------------------------------------------------
// Usage:
//   A request (in_data, eight signed 16-bit samples) is taken at a rising
//   edge with start high and busy low. The frame then leaves one byte per
//   cycle on out_data with out_strobe high: sample low byte, high byte, in
//   channel order, then CRC low and CRC high (frame_end set on the last).
//   Byte 0 appears the cycle after the request edge. busy drops while the
//   last byte is on the ports, so the next request is taken there and
//   frames follow with no gap. The rate is one byte per cycle on the
//   single output port.
//   Eight CRC lanes run in parallel at the request edge; the merge stage
//   folds them one per cycle and has the CRC ready well before the
//   trailer is sent.
//   Reset (rst_n low, synchronous) drops any frame in flight and clears
//   busy and out_strobe. The receiver cannot stall: each byte is valid for
//   exactly one cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scope_frame_crc16_builder_top import sfcb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  output logic     out_strobe,
  output out_res_t out_data
);

  logic signed [15:0] smp      [CHANNELS];
  logic        [15:0] lane_crc [CHANNELS];
  logic signed [15:0] samp_r   [CHANNELS];
  logic        [15:0] crc;
  logic        [15:0] sel;
  logic        [IDX_W-1:0] idx_r;
  logic               active_r;
  logic               accept;

  // unpack request into channel order
  assign smp[0] = in_data.sample_ch0;
  assign smp[1] = in_data.sample_ch1;
  assign smp[2] = in_data.sample_ch2;
  assign smp[3] = in_data.sample_ch3;
  assign smp[4] = in_data.sample_ch4;
  assign smp[5] = in_data.sample_ch5;
  assign smp[6] = in_data.sample_ch6;
  assign smp[7] = in_data.sample_ch7;

  // per-channel CRC lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    sfcb_lane u_lane (
      .sample   (smp[g]),
      .lane_crc (lane_crc[g])
    );
  end

  // free on the final byte so frames run back to back
  assign busy   = active_r && (idx_r != IDX_CRC_HI);
  assign accept = start && !busy;

  sfcb_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .lane_crc (lane_crc),
    .crc      (crc)
  );

  // sample store
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r <= smp;
    end
  end

  // byte sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else if (accept) begin
      active_r <= 1'b1;
      idx_r    <= '0;
    end else if (active_r) begin
      if (idx_r == IDX_CRC_HI) begin
        active_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // output byte select
  assign sel = samp_r[idx_r[3:1]];

  always_comb begin
    out_data.frame_end = (idx_r == IDX_CRC_HI);
    priority if (idx_r == IDX_CRC_HI) begin
      out_data.frame_byte = crc[15:8];
    end else if (idx_r == IDX_CRC_LO) begin
      out_data.frame_byte = crc[7:0];
    end else if (idx_r[0]) begin
      out_data.frame_byte = sel[15:8];
    end else begin
      out_data.frame_byte = sel[7:0];
    end
  end

  assign out_strobe = active_r;

endmodule

[hdl/sfcb_lane.sv]
// ---------------------------------------------------------------------------
// sfcb_lane
// Zero-init CRC-16/MODBUS of one channel sample, low byte then high byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcb_lane import sfcb_pkg::*; (
  input  logic signed [15:0] sample,
  output logic        [15:0] lane_crc
);

  // partial CRC; the merge stage folds in position and init value
  assign lane_crc = crc_byte(crc_byte(16'h0000, sample[7:0]), sample[15:8]);

endmodule

[hdl/sfcb_merge.sv]
// ---------------------------------------------------------------------------
// sfcb_merge
// Folds the lane CRCs into the frame CRC, one lane per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcb_merge import sfcb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [15:0] lane_crc [CHANNELS],
  output logic [15:0] crc
);

  localparam int CNT_W = $clog2(CHANNELS);

  logic [15:0]      lane_r [CHANNELS];
  logic [15:0]      acc_r;
  logic [15:0]      acc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;

  // crc(A,B) = adv16(crc(A)) ^ crc0(B), starting from the init value
  assign acc_nxt = crc_adv16(acc_r) ^ lane_r[cnt_r];

  // lane capture, payload only
  always_ff @(posedge clk) begin
    if (load) begin
      lane_r <= lane_crc;
    end
  end

  // accumulator and lane counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      acc_r <= CRC_INIT;
    end else if (load) begin
      run_r <= 1'b1;
      cnt_r <= '0;
      acc_r <= CRC_INIT;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(CHANNELS - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  assign crc = acc_r;

endmodule

[hdl/sfcb_checker.sv]
// ---------------------------------------------------------------------------
// sfcb_checker
// Port-level checks on the frame builder's request and byte stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scope_frame_crc16_builder_top_defines.svh"

module sfcb_checker import sfcb_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input out_res_t out_data
);

  // a taken request starts its frame on the next cycle
  `SFCB_ASSERT_NEXT(a_req_starts, start && !busy, out_strobe && !out_data.frame_end, "request did not start a frame")

  // mid-frame bytes keep the block busy
  `SFCB_ASSERT_NOW(a_mid_busy, out_strobe && !out_data.frame_end, busy, "not busy in mid frame")

  // no frame in flight means no busy
  `SFCB_ASSERT_NOW(a_idle_free, !out_strobe, !busy, "busy with no frame in flight")

  // after the last byte, bytes continue only if a new request came in
  `SFCB_ASSERT_NEXT(a_end_gap, out_strobe && out_data.frame_end, out_strobe == $past(start), "stream after frame end without request")

endmodule

bind scope_frame_crc16_builder_top sfcb_checker u_sfcb_checker (.*);

[tb/scope_frame_crc16_builder_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scope_frame_crc16_builder_top_tb
// Self-checking bench for the scope frame builder with CRC-16/MODBUS trailer.
// Frames of eight samples are sent as start/busy requests. Directed frames
// cover extreme values, a back-to-back burst runs with no gaps, and then
// random frames run with random gaps. Each frame is predicted here as 18
// bytes, and every strobed output byte is compared with the oldest one.
// ---------------------------------------------------------------------------

module scope_frame_crc16_builder_top_tb import sfcb_pkg::*;;

  localparam int RANDOM_FRAMES   = 400;
  localparam int BURST_FRAMES    = 20;
  localparam int DRAIN_LIMIT     = 400;
  localparam int TAIL_CYCLES     = 40;
  localparam int MAX_REPORTS     = 10;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_data = '0;
  logic     out_strobe;
  out_res_t out_data;

  // bytes still to come from the block, oldest first
  out_res_t pending_bytes[$];
  int       error_count = 0;

  scope_frame_crc16_builder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #400us;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------

  // reflected CRC-16, one data bit per step, LSB first
  function automatic logic [15:0] modbus_crc_feed(input logic [15:0] crc,
                                                  input logic [7:0]  data);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int b = 0; b < 8; b++) begin
      fb  = acc[0] ^ data[b];
      acc = {1'b0, acc[15:1]};
      if (fb) acc = acc ^ 16'hA001;
    end
    return acc;
  endfunction

  // queue the 18 bytes a frame must produce
  function automatic void push_expected_frame(input in_req_t req);
    logic [15:0] words[8];
    logic [15:0] crc;
    out_res_t    item;
    words[0] = req.sample_ch0;
    words[1] = req.sample_ch1;
    words[2] = req.sample_ch2;
    words[3] = req.sample_ch3;
    words[4] = req.sample_ch4;
    words[5] = req.sample_ch5;
    words[6] = req.sample_ch6;
    words[7] = req.sample_ch7;
    crc = 16'hFFFF;
    item.frame_end = 1'b0;
    for (int ch = 0; ch < 8; ch++) begin
      item.frame_byte = words[ch][7:0];
      pending_bytes.push_back(item);
      crc = modbus_crc_feed(crc, words[ch][7:0]);
      item.frame_byte = words[ch][15:8];
      pending_bytes.push_back(item);
      crc = modbus_crc_feed(crc, words[ch][15:8]);
    end
    item.frame_byte = crc[7:0];
    pending_bytes.push_back(item);
    item.frame_byte = crc[15:8];
    item.frame_end  = 1'b1;
    pending_bytes.push_back(item);
  endfunction

  // ---------------------------------------------------------------------
  // Output checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_strobe) begin
      if (pending_bytes.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected byte: frame_byte=%02h frame_end=%0b",
                   out_data.frame_byte, out_data.frame_end);
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.frame_byte !== want.frame_byte ||
            out_data.frame_end !== want.frame_end) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected byte=%02h end=%0b, got byte=%02h end=%0b",
                     want.frame_byte, want.frame_end,
                     out_data.frame_byte, out_data.frame_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------

  // random gap (noise on the data lines), then hold start until taken
  task automatic send_frame(input in_req_t req, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start   <= 1'b0;
      in_data <= {$urandom, $urandom, $urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    push_expected_frame(req);
  endtask

  // sample mix: full range, edge values, small magnitudes
  function automatic logic [15:0] random_sample();
    logic [15:0] s;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: s = 16'h8000;
          1: s = 16'h7FFF;
          2: s = 16'hFFFF;
          3: s = 16'h0000;
          default: s = 16'h0001;
        endcase
      end
      1: s = 16'($signed($urandom_range(0, 32)) - 16);
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  function automatic in_req_t random_frame();
    in_req_t r;
    r.sample_ch0 = random_sample();
    r.sample_ch1 = random_sample();
    r.sample_ch2 = random_sample();
    r.sample_ch3 = random_sample();
    r.sample_ch4 = random_sample();
    r.sample_ch5 = random_sample();
    r.sample_ch6 = random_sample();
    r.sample_ch7 = random_sample();
    return r;
  endfunction

  function automatic in_req_t fill_frame(input logic [15:0] v);
    in_req_t r;
    r = {8{v}};
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // uniform extremes, bit patterns, per-channel distinct values
  task automatic test_directed_frames();
    in_req_t r;
    send_frame(fill_frame(16'h0000), 1'b0);
    send_frame(fill_frame(16'h7FFF), 1'b0);
    send_frame(fill_frame(16'h8000), 1'b0);
    send_frame(fill_frame(16'hFFFF), 1'b0);
    send_frame(fill_frame(16'h0001), 1'b0);
    send_frame(fill_frame(16'h5555), 1'b0);
    send_frame(fill_frame(16'hAAAA), 1'b0);
    // ramp so channel order and byte order show up
    r = {16'h0700, 16'h0601, 16'h0502, 16'h0403,
         16'h0304, 16'h0205, 16'h0106, 16'h0007};
    send_frame(r, 1'b0);
    // most negative and most positive alternating, phase flipped after channel 3
    r = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
         16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    send_frame(r, 1'b0);
    // single set bit stepping through channels 7, 5, 3 and 1
    for (int k = 0; k < 4; k++) begin
      r = '0;
      r[k * 33] = 1'b1;
      send_frame(r, 1'b0);
    end
  endtask

  // frames offered with no gap, so each is taken on the last byte
  task automatic test_back_to_back();
    for (int n = 0; n < BURST_FRAMES; n++)
      send_frame(random_frame(), 1'b1);
  endtask

  // random frames with random gaps, some bursts without gaps
  task automatic test_random_frames();
    bit dense;
    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (n % 50 == 0) dense = ($urandom_range(0, 2) == 0);
      send_frame(random_frame(), dense);
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    int waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_back_to_back();
    test_random_frames();
    start <= 1'b0;

    // drain outstanding bytes, then let the block settle
    waited = 0;
    while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending_bytes.size() != 0)
        $display("%0d expected bytes never arrived", pending_bytes.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
